// ----- rtl/core/seb_pkg.sv -----
// Shared types, codes and constants of the stereo multi-tap echo buffer.
package seb_pkg;

    // Store depth in words; a power of two from 16 to 65536.
    localparam int DEPTH  = 16384;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int CMP_W  = 32;

    localparam int OFFSET_W  = 14;
    localparam int SPACING_W = 12;
    localparam int CFG_W     = 14;

    localparam logic [OFFSET_W-1:0]  DELAY_OFFSET_RESET = 14'd12000;
    localparam logic [SPACING_W-1:0] TAP_SPACING_RESET  = 12'd0;

    localparam int NUM_TAPS = 5;
    localparam int TAP_W    = 3;
    localparam logic [TAP_W-1:0] FIRST_TAP = 3'd0;
    localparam logic [TAP_W-1:0] LAST_ECHO_TAP = TAP_W'(NUM_TAPS - 1);

    typedef enum logic [0:0] {
        CFG_DELAY_OFFSET = 1'b0,
        CFG_TAP_SPACING  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_ECHO = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_SPACING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] sample_in;
    } in_word_t;

    typedef struct packed {
        logic [31:0] sample_out;
        status_t     status;
        logic        is_empty;
        logic        is_full;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             in_ready;
        logic             capture;
        logic             write_put;
        logic             clear_acc;
        logic             issue_read;
        logic [TAP_W-1:0] tap_idx;
        logic             load_out;
        logic             advance_read;
        logic             use_acc;
        status_t          status_code;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic empty;
        logic spacing_err;
        logic depth_err;
        logic out_busy;
    } ctl_status_t;

endpackage

// ----- rtl/core/seb_ctrl.sv -----
// Controller state machine of the stereo multi-tap echo buffer.
module seb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  seb_pkg::ctl_status_t stat,
    output seb_pkg::ctl_cmd_t    cmd
);

    seb_pkg::state_t                  state_reg, state_next;
    logic [seb_pkg::TAP_W-1:0]        tap_cnt_reg, tap_cnt_next;
    logic [seb_pkg::TAP_W-1:0]        last_tap_reg, last_tap_next;
    seb_pkg::status_t                 status_reg, status_next;
    logic                             use_acc_reg, use_acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= seb_pkg::S_IDLE;
            tap_cnt_reg  <= seb_pkg::FIRST_TAP;
            last_tap_reg <= seb_pkg::FIRST_TAP;
            status_reg   <= seb_pkg::ST_OK;
            use_acc_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_cnt_reg  <= tap_cnt_next;
            last_tap_reg <= last_tap_next;
            status_reg   <= status_next;
            use_acc_reg  <= use_acc_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            seb_pkg::S_IDLE: begin
                if (s_valid) state_next = seb_pkg::S_EXEC;
            end
            seb_pkg::S_EXEC: begin
                state_next = seb_pkg::S_FINISH;
                if (stat.op == seb_pkg::OP_GET && !stat.empty) begin
                    state_next = seb_pkg::S_READ;
                end else if (stat.op == seb_pkg::OP_ECHO && !stat.spacing_err &&
                             !stat.empty && !stat.depth_err) begin
                    state_next = seb_pkg::S_READ;
                end
            end
            seb_pkg::S_READ: begin
                if (tap_cnt_reg == last_tap_reg) state_next = seb_pkg::S_DRAIN;
            end
            seb_pkg::S_DRAIN: begin
                state_next = seb_pkg::S_FINISH;
            end
            seb_pkg::S_FINISH: begin
                if (!stat.out_busy) state_next = seb_pkg::S_IDLE;
            end
            default: state_next = seb_pkg::S_IDLE;
        endcase
    end

    // Per-word control registers, settled when the operation is decoded.
    always_comb begin
        tap_cnt_next  = tap_cnt_reg;
        last_tap_next = last_tap_reg;
        status_next   = status_reg;
        use_acc_next  = use_acc_reg;
        if (state_reg == seb_pkg::S_EXEC) begin
            tap_cnt_next  = seb_pkg::FIRST_TAP;
            last_tap_next = seb_pkg::FIRST_TAP;
            status_next   = seb_pkg::ST_OK;
            use_acc_next  = 1'b0;
            case (stat.op)
                seb_pkg::OP_GET: begin
                    if (stat.empty) begin
                        status_next = seb_pkg::ST_EMPTY;
                    end else begin
                        use_acc_next = 1'b1;
                    end
                end
                seb_pkg::OP_ECHO: begin
                    // The spacing test wins over the empty test.
                    if (stat.spacing_err) begin
                        status_next = seb_pkg::ST_SPACING;
                    end else if (stat.empty) begin
                        status_next = seb_pkg::ST_EMPTY;
                    end else if (stat.depth_err) begin
                        status_next = seb_pkg::ST_SPACING;
                    end else begin
                        use_acc_next  = 1'b1;
                        last_tap_next = seb_pkg::LAST_ECHO_TAP;
                    end
                end
                default: ;
            endcase
        end else if (state_reg == seb_pkg::S_READ) begin
            tap_cnt_next = tap_cnt_reg + seb_pkg::TAP_W'(1);
        end
    end

    // Command outputs.
    always_comb begin
        cmd              = '0;
        cmd.tap_idx      = tap_cnt_reg;
        cmd.use_acc      = use_acc_reg;
        cmd.status_code  = status_reg;
        unique case (state_reg)
            seb_pkg::S_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.capture  = s_valid;
            end
            seb_pkg::S_EXEC: begin
                cmd.clear_acc = 1'b1;
                cmd.write_put = (stat.op == seb_pkg::OP_PUT);
            end
            seb_pkg::S_READ: begin
                cmd.issue_read = 1'b1;
            end
            seb_pkg::S_DRAIN: ;
            seb_pkg::S_FINISH: begin
                cmd.load_out     = !stat.out_busy;
                cmd.advance_read = !stat.out_busy && use_acc_reg;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/seb_datapath.sv -----
// Datapath of the stereo multi-tap echo buffer: store, pointers, taps and output register.
module seb_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  seb_pkg::cfg_index_t          cfg_index,
    input  logic [seb_pkg::CFG_W-1:0]    cfg_data,
    input  seb_pkg::in_word_t            s_data,
    input  logic                         m_ready,
    output logic                         m_valid,
    output seb_pkg::out_word_t           m_data,
    input  seb_pkg::ctl_cmd_t            cmd,
    output seb_pkg::ctl_status_t         stat
);

    localparam int PTR_W = seb_pkg::PTR_W;
    localparam int CNT_W = seb_pkg::CNT_W;
    localparam int CMP_W = seb_pkg::CMP_W;

    logic [31:0] mem [seb_pkg::DEPTH];

    logic [seb_pkg::OFFSET_W-1:0]  delay_offset_reg;
    logic [seb_pkg::SPACING_W-1:0] tap_spacing_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] tap_back_reg, tap_back_next;

    seb_pkg::in_word_t  item_reg;
    logic [31:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic               rd_zero_reg;
    logic [seb_pkg::TAP_W-1:0] rd_tap_reg;
    logic [15:0]        acc_left_reg, acc_right_reg;
    logic               m_valid_reg;
    seb_pkg::out_word_t m_data_reg;

    logic [PTR_W-1:0] wp_plus1;
    logic [PTR_W-1:0] rp_plus1;
    logic [PTR_W-1:0] rd_addr;
    logic             rd_written;
    logic [31:0]      tap_word;
    logic [15:0]      tap_left, tap_right;

    assign wp_plus1 = wp_reg + PTR_W'(1);
    assign rp_plus1 = rp_reg + PTR_W'(1);
    // Offset and spacing wrap modulo the power-of-two depth.
    assign rd_addr  = rp_reg + PTR_W'(delay_offset_reg) - tap_back_reg;
    // Writes fill the store from entry zero upward, so the fill count marks what was written.
    assign rd_written = ({1'b0, rd_addr} < fill_reg);

    assign tap_word  = rd_zero_reg ? 32'd0 : rd_data_reg;
    assign tap_left  = 16'($signed(tap_word[15:0])  >>> rd_tap_reg);
    assign tap_right = 16'($signed(tap_word[31:16]) >>> rd_tap_reg);

    assign stat.op          = item_reg.op;
    assign stat.empty       = (wp_reg == rp_reg);
    assign stat.spacing_err = ({1'b0, tap_spacing_reg, 2'b00} >= {1'b0, delay_offset_reg});
    assign stat.depth_err   = (CMP_W'(delay_offset_reg) > CMP_W'(seb_pkg::DEPTH));
    assign stat.out_busy    = m_valid_reg && !m_ready;

    always_comb begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        fill_next     = fill_reg;
        tap_back_next = tap_back_reg;
        if (cmd.write_put) begin
            wp_next = wp_plus1;
            // A full store drops its oldest word.
            if (wp_plus1 == rp_reg) rp_next = rp_plus1;
            if (fill_reg != CNT_W'(seb_pkg::DEPTH)) fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.advance_read) rp_next = rp_plus1;
        if (cmd.clear_acc) begin
            tap_back_next = '0;
        end else if (cmd.issue_read) begin
            tap_back_next = tap_back_reg + PTR_W'(tap_spacing_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_offset_reg <= seb_pkg::DELAY_OFFSET_RESET;
            tap_spacing_reg  <= seb_pkg::TAP_SPACING_RESET;
            wp_reg           <= '0;
            rp_reg           <= '0;
            fill_reg         <= '0;
            tap_back_reg     <= '0;
            rd_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    seb_pkg::CFG_DELAY_OFFSET: delay_offset_reg <= cfg_data;
                    seb_pkg::CFG_TAP_SPACING:
                        tap_spacing_reg <= cfg_data[seb_pkg::SPACING_W-1:0];
                    default: ;
                endcase
            end
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            fill_reg     <= fill_next;
            tap_back_reg <= tap_back_next;
            rd_valid_reg <= cmd.issue_read;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.write_put) mem[wp_reg] <= item_reg.sample_in;
        if (cmd.issue_read) rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= s_data;
        if (cmd.issue_read) begin
            rd_tap_reg  <= cmd.tap_idx;
            rd_zero_reg <= !rd_written;
        end
        if (cmd.clear_acc) begin
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
        end else if (rd_valid_reg) begin
            acc_left_reg  <= acc_left_reg + tap_left;
            acc_right_reg <= acc_right_reg + tap_right;
        end
        if (cmd.load_out) begin
            m_data_reg.sample_out <= cmd.use_acc ? {acc_right_reg, acc_left_reg} : 32'd0;
            m_data_reg.status     <= cmd.status_code;
            m_data_reg.is_empty   <= (wp_next == rp_next);
            m_data_reg.is_full    <= ((wp_next + PTR_W'(1)) == rp_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/stereo_multitap_echo_buffer.sv -----
// Top level of the stereo multi-tap echo buffer: controller, datapath and checks.
//
// Input words arrive on s_valid/s_ready/s_data (op and packed stereo sample),
// one result word leaves on m_valid/m_ready/m_data for every input word.
// delay_offset and tap_spacing are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block itself leaves unenforced.
// One word is worked on at a time. A put, an unused op or a rejected get goes
// from decode straight to the result; a plain get reads one tap and an echo
// get five, through the single read port of the sample store, which delivers
// one tap per cycle. The result register is loaded in the finish state, after
// the last tap, if any, has been summed.
// s_ready is high whenever no word is in work, even while a finished result
// still waits in the output register. When the receiver stalls, the next word
// is worked up to its result and then held until the output register frees.
// Reset empties the store at once: a fill count marks which entries were
// written, and unwritten entries read as zero, so no clearing pass is needed.
// Registers return to delay_offset 12000 and tap_spacing 0.
module stereo_multitap_echo_buffer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  seb_pkg::cfg_index_t          cfg_index,
    input  logic [seb_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  seb_pkg::in_word_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output seb_pkg::out_word_t           m_data
);

    seb_pkg::ctl_cmd_t    cmd;
    seb_pkg::ctl_status_t stat;

    seb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .cmd     (cmd)
    );

    seb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign s_ready = cmd.in_ready;

    // A word in work blocks the next one.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in work");

    // A failed word never carries sample data.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != seb_pkg::ST_OK |-> m_data.sample_out == 32'd0)
        else $error("error result carries sample data");

    // The store cannot be empty and full at once.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_empty && m_data.is_full))
        else $error("empty and full flagged together");

    // The result register is loaded only when it is free or being emptied.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_valid || m_ready)
        else $error("result register overwritten before it was taken");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the stereo multi-tap echo buffer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 4_000_000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 250;
    localparam int FILL_ITEMS  = 200;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_FIRST  = 150;
    localparam int HOLD_SECOND = 1200;
    localparam int NO_HOLD     = 32'h7fff_ffff;

    // Mirror of the buffer state; predicts one result word per accepted input word.
    class echo_buffer_book;
        bit [31:0]                   store [seb_pkg::DEPTH];
        bit [seb_pkg::PTR_W-1:0]     wr_ptr;
        bit [seb_pkg::PTR_W-1:0]     rd_ptr;
        bit [seb_pkg::OFFSET_W-1:0]  offset;
        bit [seb_pkg::SPACING_W-1:0] spacing;
        seb_pkg::out_word_t          awaited [$];
        int checked, mismatches;
        int puts, gets, echoes, idles, empty_errs, spacing_errs, full_seen;

        function new();
            offset  = seb_pkg::DELAY_OFFSET_RESET;
            spacing = seb_pkg::TAP_SPACING_RESET;
        endfunction

        function void set_config(logic [seb_pkg::CFG_W-1:0] off,
                                 logic [seb_pkg::CFG_W-1:0] sp);
            offset  = off[seb_pkg::OFFSET_W-1:0];
            spacing = sp[seb_pkg::SPACING_W-1:0];
        endfunction

        function seb_pkg::out_word_t step_buffer(seb_pkg::in_word_t w);
            seb_pkg::out_word_t      r;
            bit                      was_empty;
            bit [seb_pkg::PTR_W-1:0] idx;
            bit [15:0]               sum_l;
            bit [15:0]               sum_r;
            bit [31:0]               tap;
            int                      k;
            r = '0;
            sum_l = '0;
            sum_r = '0;
            was_empty = (wr_ptr == rd_ptr);
            case (w.op)
                seb_pkg::OP_PUT: begin
                    store[wr_ptr] = w.sample_in;
                    wr_ptr = wr_ptr + seb_pkg::PTR_W'(1);
                    // A full store drops its oldest word.
                    if (wr_ptr == rd_ptr)
                        rd_ptr = rd_ptr + seb_pkg::PTR_W'(1);
                end
                seb_pkg::OP_GET: begin
                    if (was_empty) begin
                        r.status = seb_pkg::ST_EMPTY;
                    end else begin
                        idx = rd_ptr + offset;
                        r.sample_out = store[idx];
                        rd_ptr = rd_ptr + seb_pkg::PTR_W'(1);
                    end
                end
                seb_pkg::OP_ECHO: begin
                    // The spacing test wins over the empty test.
                    if (4 * int'(spacing) >= int'(offset)) begin
                        r.status = seb_pkg::ST_SPACING;
                    end else if (was_empty) begin
                        r.status = seb_pkg::ST_EMPTY;
                    end else if (seb_pkg::DEPTH < int'(offset)) begin
                        r.status = seb_pkg::ST_SPACING;
                    end else begin
                        for (k = 0; k < seb_pkg::NUM_TAPS; k++) begin
                            idx = seb_pkg::PTR_W'(int'(rd_ptr) + int'(offset) -
                                                  k * int'(spacing));
                            tap = store[idx];
                            sum_l += 16'($signed(tap[15:0]) >>> k);
                            sum_r += 16'($signed(tap[31:16]) >>> k);
                        end
                        r.sample_out = {sum_r, sum_l};
                        rd_ptr = rd_ptr + seb_pkg::PTR_W'(1);
                    end
                end
                default: ;
            endcase
            r.is_empty = (wr_ptr == rd_ptr);
            r.is_full  = ((wr_ptr + seb_pkg::PTR_W'(1)) == rd_ptr);
            return r;
        endfunction

        function void note_word(seb_pkg::in_word_t w);
            seb_pkg::out_word_t e;
            e = step_buffer(w);
            awaited.push_back(e);
            case (w.op)
                seb_pkg::OP_PUT:  puts++;
                seb_pkg::OP_GET:  gets++;
                seb_pkg::OP_ECHO: echoes++;
                default: idles++;
            endcase
            if (e.status == seb_pkg::ST_EMPTY)
                empty_errs++;
            if (e.status == seb_pkg::ST_SPACING)
                spacing_errs++;
            if (e.is_full)
                full_seen++;
        endfunction

        function void check_word(seb_pkg::out_word_t got);
            seb_pkg::out_word_t e;
            checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result word %h arrived with nothing expected.", got);
                return;
            end
            e = awaited.pop_front();
            if (got.sample_out !== e.sample_out || got.status !== e.status ||
                got.is_empty !== e.is_empty || got.is_full !== e.is_full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Result %0d: expected sample %h status %0d empty %b full %b, ",
                              "got sample %h status %0d empty %b full %b"},
                             checked, e.sample_out, e.status, e.is_empty, e.is_full,
                             got.sample_out, got.status, got.is_empty, got.is_full);
            end
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    seb_pkg::cfg_index_t       cfg_index = seb_pkg::CFG_DELAY_OFFSET;
    logic [seb_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    seb_pkg::in_word_t         s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    seb_pkg::out_word_t        m_data;

    echo_buffer_book book;
    int cycles = 0;
    int burst_left = 0;

    stereo_multitap_echo_buffer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_word(m_data);
    end

    // Receiver: changing stall patterns, plus two long hold-offs that back the block up.
    initial begin : receiver
        int mode;
        int mode_left;
        int tick;
        int hold_count;
        int next_hold;
        mode = 0;
        mode_left = 0;
        tick = 0;
        next_hold = HOLD_FIRST;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            tick++;
            if (book.checked >= next_hold) begin
                m_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < LONG_HOLD) begin
                    @(negedge aclk);
                    hold_count++;
                end
                next_hold = (next_hold == HOLD_FIRST) ? HOLD_SECOND : NO_HOLD;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (tick % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic offer_word(input seb_pkg::op_t op, input logic [31:0] sample);
        seb_pkg::in_word_t w;
        int gap;
        w.op = op;
        w.sample_in = sample;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        book.note_word(w);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (book.awaited.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Writes both registers; spare high bits of the spacing word are random.
    task automatic write_regs(input int off, input int sp);
        logic [seb_pkg::CFG_W-1:0] sp_word;
        sp_word = seb_pkg::CFG_W'(sp);
        sp_word[seb_pkg::CFG_W-1:seb_pkg::SPACING_W] =
            (seb_pkg::CFG_W - seb_pkg::SPACING_W)'($urandom_range(0, 3));
        cfg_we <= 1'b1;
        cfg_index <= seb_pkg::CFG_DELAY_OFFSET;
        cfg_data <= seb_pkg::CFG_W'(off);
        @(negedge aclk);
        cfg_index <= seb_pkg::CFG_TAP_SPACING;
        cfg_data <= sp_word;
        @(negedge aclk);
        cfg_we <= 1'b0;
        book.set_config(seb_pkg::CFG_W'(off), sp_word);
    endtask

    task automatic pick_config(input int kind);
        int off;
        int sp;
        case (kind)
            0: begin
                off = $urandom_range(1, 64);
                sp = $urandom_range(0, (off - 1) / 4);
            end
            1: begin
                off = 16383;
                sp = 4095;
            end
            2: begin
                off = $urandom_range(0, 16383);
                sp = $urandom_range(0, 4095);
            end
            3: begin
                off = $urandom_range(4, 400);
                sp = $urandom_range(0, (off - 1) / 4);
            end
            4: begin
                off = 0;
                sp = $urandom_range(0, 4095);
            end
            default: begin
                off = $urandom_range(1, 16383);
                sp = $urandom_range(0, (off - 1) / 4);
            end
        endcase
        write_regs(off, sp);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] corner [4];
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_8000, 32'h7FFF_7FFF};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    task automatic offer_random(input int put_pct);
        int pick;
        int span;
        seb_pkg::op_t op;
        pick = $urandom_range(0, 99);
        span = 100 - put_pct;
        if (pick < put_pct)
            op = seb_pkg::OP_PUT;
        else if (pick - put_pct < span * 4 / 10)
            op = seb_pkg::OP_GET;
        else if (pick - put_pct < span * 9 / 10)
            op = seb_pkg::OP_ECHO;
        else
            op = seb_pkg::OP_NONE;
        offer_word(op, random_sample());
    endtask

    initial begin : stimulus
        logic [31:0] corner_puts [6];
        int i;
        int p;
        corner_puts = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_8000,
                        32'h7FFF_7FFF, 32'h8000_7FFF, 32'h5555_AAAA};
        book = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Gets on the empty store with reset settings, and the unused op code.
        offer_word(seb_pkg::OP_GET, 32'h0);
        offer_word(seb_pkg::OP_ECHO, 32'h0);
        offer_word(seb_pkg::OP_NONE, 32'hFFFF_FFFF);
        drain();
        // Four times the spacing equals the offset: spacing error even while empty.
        write_regs(12000, 3000);
        offer_word(seb_pkg::OP_ECHO, 32'h0);
        drain();
        write_regs(0, 0);
        for (i = 0; i < 6; i++)
            offer_word(seb_pkg::OP_PUT, corner_puts[i]);
        offer_word(seb_pkg::OP_GET, 32'h0);
        offer_word(seb_pkg::OP_GET, 32'h0);
        offer_word(seb_pkg::OP_ECHO, 32'h0);
        offer_word(seb_pkg::OP_NONE, 32'h0);
        drain();
        // Taps fall on the corner words, so the per-channel sums wrap.
        write_regs(4, 1);
        offer_word(seb_pkg::OP_ECHO, 32'h0);
        offer_word(seb_pkg::OP_ECHO, 32'h0);
        offer_word(seb_pkg::OP_GET, 32'h0);
        drain();
        write_regs(16383, 4095);
        offer_word(seb_pkg::OP_ECHO, 32'h0);
        offer_word(seb_pkg::OP_GET, 32'h0);
        drain();

        // Near-empty store: the empty case comes up often.
        for (p = 0; p < 3; p++) begin
            pick_config(p);
            for (i = 0; i < PHASE_ITEMS; i++)
                offer_random(45);
            drain();
        end

        // A long run of puts builds up a backlog, then gets are mixed in.
        pick_config(5);
        for (i = 0; i < FILL_ITEMS; i++)
            offer_word(seb_pkg::OP_PUT, $urandom);
        for (i = 0; i < 60; i++)
            offer_random(50);
        drain();

        // Taps reach both written entries and entries still cleared from reset.
        for (p = 3; p < 6; p++) begin
            pick_config(p);
            for (i = 0; i < PHASE_ITEMS; i++)
                offer_random(45 + 5 * (p - 3));
            drain();
        end

        $display("Run covered %0d puts, %0d plain gets, %0d echo gets, %0d unused-op words",
                 book.puts, book.gets, book.echoes, book.idles);
        $display("in %0d cycles; empty errors %0d, spacing errors %0d, full flags %0d.",
                 cycles, book.empty_errs, book.spacing_errs, book.full_seen);
        if (book.mismatches == 0 && book.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/seb_pkg.sv
rtl/core/seb_ctrl.sv
rtl/core/seb_datapath.sv
rtl/core/stereo_multitap_echo_buffer.sv
tb/testbench.sv
